// ----- rtl/crsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsi_pkg
// Shared types and constants for the Catmull-Rom segment interpolator.
// ----------------------------------------------------------------------------
package crsi_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int T_BITS      = FRAC_BITS + 1;
  localparam int KIND_BITS   = 2;
  // basis sums reach 12 times a sample
  localparam int COEF_BITS   = SAMPLE_BITS + 4;
  // each horner step grows the accumulator by the width of t
  localparam int ACC_BITS    = COEF_BITS + 3 * T_BITS;
  localparam int SCALED_BITS = ACC_BITS - 3 * FRAC_BITS - 1;

  localparam logic [KIND_BITS-1:0] KIND_INTERIOR = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_FIRST    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_LAST     = 2'd2;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic [T_BITS-1:0]           t_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]          kind;
    logic signed [SAMPLE_BITS-1:0] p0;
    logic signed [SAMPLE_BITS-1:0] p1;
    logic signed [SAMPLE_BITS-1:0] p2;
    logic signed [SAMPLE_BITS-1:0] p3;
    logic [T_BITS-1:0]             frac;
  } crsi_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clipped;
  } crsi_out_t;

endpackage

// ----- rtl/crsi_basis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsi_basis
// First pipeline stage: clamps t and forms the four polynomial coefficients
// of the selected basis from the control samples.
// ----------------------------------------------------------------------------
module crsi_basis import crsi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_vld_i,
  output logic     up_rdy_o,
  input  crsi_in_t up_data_i,
  output logic     dn_vld_o,
  input  logic     dn_rdy_i,
  output coef_t    c0_o,
  output coef_t    c1_o,
  output coef_t    c2_o,
  output coef_t    c3_o,
  output t_t       t_o
);

  localparam int EXT = COEF_BITS - SAMPLE_BITS;

  logic  vld_r;
  coef_t s0, s1, s2, s3;
  coef_t c0_nxt, c1_nxt, c2_nxt, c3_nxt;
  t_t    t_nxt;
  coef_t c0_r, c1_r, c2_r, c3_r;
  t_t    t_r;

  assign up_rdy_o = !vld_r || dn_rdy_i;

  assign s0 = {{EXT{up_data_i.p0[SAMPLE_BITS-1]}}, up_data_i.p0};
  assign s1 = {{EXT{up_data_i.p1[SAMPLE_BITS-1]}}, up_data_i.p1};
  assign s2 = {{EXT{up_data_i.p2[SAMPLE_BITS-1]}}, up_data_i.p2};
  assign s3 = {{EXT{up_data_i.p3[SAMPLE_BITS-1]}}, up_data_i.p3};

  // t above one is clamped to one
  always_comb begin
    if (up_data_i.frac[FRAC_BITS] && (|up_data_i.frac[FRAC_BITS-1:0])) begin
      t_nxt = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      t_nxt = up_data_i.frac;
    end
  end

  // constant term carries the rounding half of the final shift
  always_comb begin
    c3_nxt = (s1 <<< 1) + coef_t'(1);
    unique case (up_data_i.kind)
      KIND_FIRST: begin
        c0_nxt = '0;
        c1_nxt = s1 - (s2 <<< 1) + s3;
        c2_nxt = (s2 <<< 2) - (s1 <<< 1) - s1 - s3;
      end
      KIND_LAST: begin
        c0_nxt = '0;
        c1_nxt = s0 - (s1 <<< 1) + s2;
        c2_nxt = s2 - s0;
      end
      default: begin
        c0_nxt = (s1 <<< 1) + s1 + s3 - s0 - (s2 <<< 1) - s2;
        c1_nxt = (s0 <<< 1) + (s2 <<< 2) - (s1 <<< 2) - s1 - s3;
        c2_nxt = s2 - s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy_o) begin
      vld_r <= up_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o) begin
      c0_r <= c0_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      c3_r <= c3_nxt;
      t_r  <= t_nxt;
    end
  end

  assign dn_vld_o = vld_r;
  assign c0_o     = c0_r;
  assign c1_o     = c1_r;
  assign c2_o     = c2_r;
  assign c3_o     = c3_r;
  assign t_o      = t_r;

endmodule

// ----- rtl/crsi_horner_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsi_horner_step
// One horner step over two register stages: acc * t as two registered
// partial products, then their sum plus the aligned next coefficient.
// ----------------------------------------------------------------------------
module crsi_horner_step import crsi_pkg::*; #(
  parameter int AW     = 20,
  parameter int SHIFT  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_vld_i,
  output logic                    up_rdy_o,
  input  logic signed [AW-1:0]    acc_i,
  input  t_t                      t_i,
  input  coef_t                   coef_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    dn_vld_o,
  input  logic                    dn_rdy_i,
  output logic signed [AW+T_BITS-1:0] acc_o,
  output t_t                      t_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int LO = AW / 2;
  localparam int HI = AW - LO;
  localparam int PL = LO + T_BITS;
  localparam int PH = HI + T_BITS + 1;
  localparam int OW = AW + T_BITS;

  logic                    a_vld_r, b_vld_r;
  logic                    a_rdy, b_rdy;
  logic [LO-1:0]           lo_part;
  logic signed [HI-1:0]    hi_part;
  logic signed [T_BITS:0]  t_s;
  logic [PL-1:0]           pp_lo_nxt, pp_lo_r;
  logic signed [PH-1:0]    pp_hi_nxt, pp_hi_r;
  coef_t                   coef_r;
  t_t                      ta_r, tb_r;
  logic [SIDE_W-1:0]       sa_r, sb_r;
  logic signed [OW-1:0]    hi_ext, lo_ext, c_ext, acc_nxt, acc_r;

  assign b_rdy    = !b_vld_r || dn_rdy_i;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign up_rdy_o = a_rdy;

  assign lo_part   = acc_i[LO-1:0];
  assign hi_part   = acc_i[AW-1:LO];
  assign t_s       = {1'b0, t_i};
  assign pp_lo_nxt = lo_part * t_i;
  assign pp_hi_nxt = hi_part * t_s;

  assign hi_ext  = {{(OW-PH){pp_hi_r[PH-1]}}, pp_hi_r};
  assign lo_ext  = {{(OW-PL){1'b0}}, pp_lo_r};
  assign c_ext   = {{(OW-COEF_BITS){coef_r[COEF_BITS-1]}}, coef_r};
  assign acc_nxt = (hi_ext <<< LO) + lo_ext + (c_ext <<< SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= up_vld_i;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
      coef_r  <= coef_i;
      ta_r    <= t_i;
      sa_r    <= side_i;
    end
    if (b_rdy) begin
      acc_r <= acc_nxt;
      tb_r  <= ta_r;
      sb_r  <= sa_r;
    end
  end

  assign dn_vld_o = b_vld_r;
  assign acc_o    = acc_r;
  assign t_o      = tb_r;
  assign side_o   = sb_r;

endmodule

// ----- rtl/crsi_round_sat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsi_round_sat
// Output stage: drops the fraction of the pre-rounded sum, saturates to the
// sample range and holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
module crsi_round_sat import crsi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_vld_i,
  output logic                       up_rdy_o,
  input  logic signed [ACC_BITS-1:0] acc_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output crsi_out_t                  out_data
);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          vld_r;
  logic [SCALED_BITS-1:0]        scaled;
  logic [SCALED_BITS-SAMPLE_BITS:0] upper;
  logic                          ovf;
  crsi_out_t                     res_nxt, res_r;

  assign up_rdy_o = !vld_r || !out_stall;

  assign scaled = acc_i[ACC_BITS-1:3*FRAC_BITS+1];
  assign upper  = scaled[SCALED_BITS-1:SAMPLE_BITS-1];
  assign ovf    = !((&upper) || (~|upper));

  always_comb begin
    res_nxt.clipped = ovf;
    if (!ovf) begin
      res_nxt.value = scaled[SAMPLE_BITS-1:0];
    end else if (scaled[SCALED_BITS-1]) begin
      res_nxt.value = S_MIN;
    end else begin
      res_nxt.value = S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy_o) begin
      vld_r <= up_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = res_r;

endmodule

// ----- rtl/catmull_rom_segment_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_segment_interp
// Fixed-point uniform Catmull-Rom segment interpolator, pipelined.
//
//   channel  ports                          payload
//   input    in_valid / in_stall / in_data  kind, p0..p3, frac (crsi_in_t)
//   output   out_valid / out_stall / out_data  value, clipped (crsi_out_t)
//
// one transaction per cycle while out_stall is low; each result passes every stage below before out_valid
// stages: basis, three horner steps of two stages each, round and saturate
// each stage loads when empty or when the next one loads, so bubbles fill
// in_stall rises only when every stage holds a transaction and out_stall is set
// synchronous active-low reset clears all valid bits
// ----------------------------------------------------------------------------
module catmull_rom_segment_interp import crsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  crsi_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output crsi_out_t out_data
);

  localparam int AW1 = COEF_BITS;
  localparam int AW2 = AW1 + T_BITS;
  localparam int AW3 = AW2 + T_BITS;

  logic  bas_vld, bas_rdy;
  coef_t c0, c1, c2, c3;
  t_t    t0;

  logic                   s1_vld, s1_rdy;
  logic signed [AW2-1:0]  acc1;
  t_t                     t1;
  logic [2*COEF_BITS-1:0] side1;

  logic                   s2_vld, s2_rdy;
  logic signed [AW3-1:0]  acc2;
  t_t                     t2;
  logic [COEF_BITS-1:0]   side2;

  logic                       s3_vld, s3_rdy;
  logic signed [ACC_BITS-1:0] acc3;

  logic out_rdy;

  assign in_stall = !bas_rdy;

  crsi_basis u_basis (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld_i  (in_valid),
    .up_rdy_o  (bas_rdy),
    .up_data_i (in_data),
    .dn_vld_o  (bas_vld),
    .dn_rdy_i  (s1_rdy),
    .c0_o      (c0),
    .c1_o      (c1),
    .c2_o      (c2),
    .c3_o      (c3),
    .t_o       (t0)
  );

  crsi_horner_step #(
    .AW     (AW1),
    .SHIFT  (FRAC_BITS),
    .SIDE_W (2 * COEF_BITS)
  ) u_step1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld_i (bas_vld),
    .up_rdy_o (s1_rdy),
    .acc_i    (c0),
    .t_i      (t0),
    .coef_i   (c1),
    .side_i   ({c2, c3}),
    .dn_vld_o (s1_vld),
    .dn_rdy_i (s2_rdy),
    .acc_o    (acc1),
    .t_o      (t1),
    .side_o   (side1)
  );

  crsi_horner_step #(
    .AW     (AW2),
    .SHIFT  (2 * FRAC_BITS),
    .SIDE_W (COEF_BITS)
  ) u_step2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld_i (s1_vld),
    .up_rdy_o (s2_rdy),
    .acc_i    (acc1),
    .t_i      (t1),
    .coef_i   (side1[2*COEF_BITS-1:COEF_BITS]),
    .side_i   (side1[COEF_BITS-1:0]),
    .dn_vld_o (s2_vld),
    .dn_rdy_i (s3_rdy),
    .acc_o    (acc2),
    .t_o      (t2),
    .side_o   (side2)
  );

  crsi_horner_step #(
    .AW     (AW3),
    .SHIFT  (3 * FRAC_BITS),
    .SIDE_W (1)
  ) u_step3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld_i (s2_vld),
    .up_rdy_o (s3_rdy),
    .acc_i    (acc2),
    .t_i      (t2),
    .coef_i   (side2),
    .side_i   (1'b0),
    .dn_vld_o (s3_vld),
    .dn_rdy_i (out_rdy),
    .acc_o    (acc3),
    .t_o      (),
    .side_o   ()
  );

  crsi_round_sat u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld_i  (s3_vld),
    .up_rdy_o  (out_rdy),
    .acc_i     (acc3),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/crsi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsi_checker
// Port-level checks for the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module crsi_checker import crsi_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input crsi_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input crsi_out_t out_data
);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // held result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // backpressure reaches the input only through a full pipeline
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |-> out_data.value == S_MAX || out_data.value == S_MIN)
    else $error("clipped result not at a range limit");

endmodule

bind catmull_rom_segment_interp crsi_checker u_crsi_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Catmull-Rom segment interpolator. A directed
// set covers the field extremes, all segment kinds, the unused kind, a
// parameter above one and saturation both ways. Then random transactions run
// in phases of sender gaps and receiver stalls. Each accepted input is
// predicted at full width and queued, and every accepted output is checked
// against the oldest queued prediction.
// ----------------------------------------------------------------------------
module tb;
  import crsi_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int ONE = 1 << FRAC_BITS;
  localparam int ITEMS_PER_PHASE = 312;

  class interp_scoreboard;
    crsi_out_t expected_values[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    // value = 0.5 * sum p_j * w_j(t), rounded half up, saturated
    function crsi_out_t interp_value(crsi_in_t x);
      int                  q0, q1, q2, q3;
      int                  a3, a2, a1, a0;
      logic signed [127:0] c3, c2, c1, c0, f, s, n, half;
      crsi_out_t           r;
      q0 = int'(x.p0);
      q1 = int'(x.p1);
      q2 = int'(x.p2);
      q3 = int'(x.p3);
      case (x.kind)
        KIND_FIRST: begin
          a3 = 0;
          a2 = q1 - 2 * q2 + q3;
          a1 = -3 * q1 + 4 * q2 - q3;
        end
        KIND_LAST: begin
          a3 = 0;
          a2 = q0 - 2 * q1 + q2;
          a1 = q2 - q0;
        end
        default: begin
          a3 = -q0 + 3 * q1 - 3 * q2 + q3;
          a2 = 2 * q0 - 5 * q1 + 4 * q2 - q3;
          a1 = q2 - q0;
        end
      endcase
      a0 = 2 * q1;
      c3 = 128'(a3);
      c2 = 128'(a2);
      c1 = 128'(a1);
      c0 = 128'(a0);
      f = (x.frac > t_t'(ONE)) ? 128'(ONE) : 128'(x.frac);
      s = 128'(ONE);
      half = 128'sd1 <<< (3 * FRAC_BITS);
      n = c3 * f * f * f + c2 * f * f * s + c1 * f * s * s + c0 * s * s * s;
      n = (n + half) >>> (3 * FRAC_BITS + 1);
      r.clipped = 1'b0;
      if (n > S_MAX) begin
        n = 128'(S_MAX);
        r.clipped = 1'b1;
      end else if (n < S_MIN) begin
        n = 128'(S_MIN);
        r.clipped = 1'b1;
      end
      r.value = n[SAMPLE_BITS-1:0];
      return r;
    endfunction

    function void add_input(crsi_in_t x);
      expected_values.push_back(interp_value(x));
    endfunction

    function void check_output(crsi_out_t y);
      crsi_out_t e;
      if (expected_values.size() == 0) begin
        $error("unexpected output value=%0d clipped=%0b", y.value, y.clipped);
        mismatches++;
        return;
      end
      e = expected_values.pop_front();
      if (y.value !== e.value) begin
        $error("value mismatch: expected %0d, actual %0d", e.value, y.value);
        mismatches++;
      end
      if (y.clipped !== e.clipped) begin
        $error("clipped mismatch: expected %0b, actual %0b", e.clipped, y.clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  crsi_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  crsi_out_t out_data;

  interp_scoreboard sb;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  catmull_rom_segment_interp i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_output(out_data);
    end
  end

  function automatic crsi_in_t make_item(logic [KIND_BITS-1:0] k, int p0, int p1, int p2,
                                         int p3, int t);
    crsi_in_t x;
    x.kind = k;
    x.p0   = sample_t'(p0);
    x.p1   = sample_t'(p1);
    x.p2   = sample_t'(p2);
    x.p3   = sample_t'(p3);
    x.frac = t_t'(t);
    return x;
  endfunction

  function automatic sample_t random_sample();
    sample_t v;
    case ($urandom_range(9))
      0:       v = S_MAX;
      1:       v = S_MIN;
      2, 3:    v = sample_t'($urandom_range(512) - 256);
      default: v = sample_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic crsi_in_t random_item();
    crsi_in_t x;
    x.kind = KIND_BITS'($urandom_range(3));
    x.p0   = random_sample();
    x.p1   = random_sample();
    x.p2   = random_sample();
    x.p3   = random_sample();
    case ($urandom_range(7))
      0:       x.frac = '0;
      1:       x.frac = t_t'(ONE);
      2:       x.frac = t_t'($urandom_range((1 << T_BITS) - 1, ONE + 1));
      default: x.frac = t_t'($urandom_range(ONE));
    endcase
    return x;
  endfunction

  // entered and left at a falling edge
  task automatic send(crsi_in_t x);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    sb.add_input(x);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_values.size() != 0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (ITEMS_PER_PHASE) send(random_item());
    drain();
  endtask

  initial begin
    sb = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(make_item(KIND_INTERIOR, 0, 0, 0, 0, 0));
    send(make_item(KIND_INTERIOR, S_MAX, S_MAX, S_MAX, S_MAX, ONE / 2));
    send(make_item(KIND_INTERIOR, S_MIN, S_MAX, S_MAX, S_MIN, ONE / 2));
    send(make_item(KIND_INTERIOR, S_MAX, S_MIN, S_MIN, S_MAX, ONE / 2));
    send(make_item(KIND_INTERIOR, 1234, -500, S_MIN, 77, ONE));
    send(make_item(KIND_INTERIOR, -3, 1000, 2000, 5, 1));
    send(make_item(KIND_INTERIOR, 999, -1000, 1000, -999, ONE - 1));
    send(make_item(KIND_INTERIOR, 1, -1, 1, -1, ONE / 2));
    send(make_item(KIND_UNUSED, S_MIN, S_MAX, S_MAX, S_MIN, ONE / 2));
    send(make_item(KIND_UNUSED, 100, 200, -300, 400, (1 << T_BITS) - 1));
    send(make_item(KIND_UNUSED, 5, S_MIN, 7, 9, 0));
    send(make_item(KIND_FIRST, S_MAX, S_MIN, S_MAX, S_MIN, ONE / 2));
    send(make_item(KIND_FIRST, S_MIN, 4321, -8765, 1, 0));
    send(make_item(KIND_FIRST, S_MIN, 4321, -8765, 1, ONE));
    send(make_item(KIND_FIRST, S_MAX, 4321, -8765, 1, ONE + 1));
    send(make_item(KIND_FIRST, 0, S_MAX, S_MIN, S_MAX, 3 * ONE / 4));
    send(make_item(KIND_LAST, S_MAX, S_MIN, S_MAX, S_MIN, ONE / 2));
    send(make_item(KIND_LAST, -7, 300, -300, S_MAX, ONE / 4));
    send(make_item(KIND_LAST, S_MIN, S_MAX, S_MIN, S_MAX, ONE / 4));
    send(make_item(KIND_LAST, 11, 22, 33, S_MIN, ONE));
    send(make_item(KIND_LAST, 11, 22, 33, S_MIN, 1));
    drain();

    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(7, 7);

    out_stall_pct = 0;
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_values.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
